// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UER_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define UER_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- hdl/uer_pkg.sv -----
package uer_pkg;

	localparam int COUNT_WIDTH_DEF = 24;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int TPC_W      = 10;
	localparam int TRIG_W     = 8;
	localparam int PRE_W      = 8;
	localparam int GAP_W      = 24;
	localparam int DIST_W     = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 24;

	localparam int DIST_MAX = 65535;

	localparam logic [TPC_W-1:0]  TPC_RST  = 10'd58;
	localparam logic [TRIG_W-1:0] TRIG_RST = 8'd10;
	localparam logic [PRE_W-1:0]  PRE_RST  = 8'd5;
	localparam logic [GAP_W-1:0]  GAP_RST  = 24'd60000;

	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_CM = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_HIGH = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRE_LOW      = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_GAP   = 8'd3;

	typedef enum logic [2:0] {
		PH_GAP,
		PH_PRE_LOW,
		PH_HIGH,
		PH_WAIT_RISE,
		PH_COUNTING
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

	// Per-tick control word passed from the front end to the back end.
	typedef struct packed {
		logic trigger;
		logic armed;
		logic measure;
	} tick_ctl_t;

	localparam int CTL_W = $bits(tick_ctl_t);

endpackage

// ----- hdl/uer_front.sv -----
module uer_front #(
	parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           echo_level,
	input  logic [uer_pkg::TRIG_W-1:0]     trigger_high_ticks,
	input  logic [uer_pkg::PRE_W-1:0]      pre_low_ticks,
	input  logic [uer_pkg::GAP_W-1:0]      repeat_gap_ticks,
	input  logic                           q_full,
	output logic                           q_push,
	output uer_pkg::tick_ctl_t             q_ctl,
	output logic [COUNT_WIDTH-1:0]         q_dividend
);
	import uer_pkg::*;

	phase_t                 phase_q, phase_nx;
	logic [GAP_W-1:0]       phase_ticks_q, phase_ticks_nx;
	logic [COUNT_WIDTH-1:0] echo_ticks_q, echo_ticks_nx;
	logic                   prev_echo_q;
	logic                   measure;
	logic                   rise, fall;

	function automatic logic is_timed(input phase_t ph);
		return (ph == PH_GAP) || (ph == PH_PRE_LOW) || (ph == PH_HIGH);
	endfunction

	function automatic logic [GAP_W-1:0] phase_len(input phase_t ph,
			input logic [GAP_W-1:0] gap, input logic [PRE_W-1:0] pre,
			input logic [TRIG_W-1:0] trig);
		logic [GAP_W-1:0] len;
		case (ph)
			PH_GAP:     len = gap;
			PH_PRE_LOW: len = GAP_W'(pre);
			default:    len = (trig == '0) ? GAP_W'(1) : GAP_W'(trig);
		endcase
		return len;
	endfunction

	function automatic phase_t phase_succ(input phase_t ph);
		phase_t nx;
		case (ph)
			PH_GAP:     nx = PH_PRE_LOW;
			PH_PRE_LOW: nx = PH_HIGH;
			PH_HIGH:    nx = PH_WAIT_RISE;
			default:    nx = PH_GAP;
		endcase
		return nx;
	endfunction

	assign rise = echo_level && !prev_echo_q;
	assign fall = !echo_level && prev_echo_q;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// Next state. A timed phase can chain through at most two zero-length phases
	// in one tick, since the trigger-high phase always lasts at least one tick.
	always_comb begin
		phase_t           p0, p1, p2;
		logic [GAP_W-1:0] t0, t1, t2;
		p0 = phase_q;
		t0 = phase_ticks_q;
		echo_ticks_nx = echo_ticks_q;
		measure = 1'b0;
		case (phase_q)
			PH_WAIT_RISE: begin
				if (rise) begin
					echo_ticks_nx = COUNT_WIDTH'(1);
					p0 = PH_COUNTING;
				end
			end
			PH_COUNTING: begin
				if (fall) begin
					measure = 1'b1;
					p0 = PH_GAP;
					t0 = '0;
				end else if (echo_level && (echo_ticks_q != '1)) begin
					echo_ticks_nx = echo_ticks_q + 1'b1;
				end
			end
			default: ;
		endcase

		if (is_timed(p0) && (t0 >= phase_len(p0, repeat_gap_ticks, pre_low_ticks,
				trigger_high_ticks))) begin
			p1 = phase_succ(p0);
			t1 = '0;
		end else begin
			p1 = p0;
			t1 = t0;
		end

		if (is_timed(p1) && (t1 >= phase_len(p1, repeat_gap_ticks, pre_low_ticks,
				trigger_high_ticks))) begin
			p2 = phase_succ(p1);
			t2 = '0;
		end else begin
			p2 = p1;
			t2 = t1;
		end

		phase_nx = p2;
		phase_ticks_nx = is_timed(p2) ? t2 + 1'b1 : t2;
	end

	// Outputs of the tick, taken from the phase it ends in.
	always_comb begin
		q_ctl.trigger = (phase_nx == PH_HIGH);
		q_ctl.armed   = (phase_nx == PH_HIGH) || (phase_nx == PH_WAIT_RISE) ||
		                (phase_nx == PH_COUNTING);
		q_ctl.measure = measure;
		q_dividend    = echo_ticks_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_GAP;
			phase_ticks_q <= '0;
			echo_ticks_q  <= '0;
			prev_echo_q   <= 1'b0;
		end else if (q_push) begin
			phase_q       <= phase_nx;
			phase_ticks_q <= phase_ticks_nx;
			echo_ticks_q  <= echo_ticks_nx;
			prev_echo_q   <= echo_level;
		end
	end

endmodule

// ----- hdl/uer_fifo.sv -----
module uer_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = uer_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	import uer_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/uer_back.sv -----
module uer_back #(
	parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [uer_pkg::TPC_W-1:0]    ticks_per_cm,
	input  logic                         q_empty,
	input  uer_pkg::tick_ctl_t           q_ctl,
	input  logic [COUNT_WIDTH-1:0]       q_dividend,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         trigger_level,
	output logic [uer_pkg::DIST_W-1:0]   distance_cm,
	output logic                         distance_valid,
	output logic                         armed
);
	import uer_pkg::*;

	localparam int CNT_W = $clog2(COUNT_WIDTH);

	back_state_t            state_q, state_nx;
	tick_ctl_t              ctl_q;
	logic [COUNT_WIDTH-1:0] quo_q;
	logic [TPC_W-1:0]       rem_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [DIST_W-1:0]      last_dist_q;

	logic                   out_valid_q, out_trig_q, out_dv_q, out_armed_q;
	logic [DIST_W-1:0]      out_dist_q;

	logic                   slot_free;
	logic                   load_div, div_step, emit_plain, emit_meas;
	logic [TPC_W-1:0]       divisor;
	logic [TPC_W:0]         shifted, diff;
	logic                   ge;
	logic [DIST_W-1:0]      dist_sat;

	assign slot_free = !out_valid_q || out_ready;

	// One restoring-division step per cycle, most significant dividend bit first.
	assign divisor  = (ticks_per_cm == '0) ? TPC_W'(1) : ticks_per_cm;
	assign shifted  = {rem_q, quo_q[COUNT_WIDTH-1]};
	assign ge       = (shifted >= {1'b0, divisor});
	assign diff     = shifted - {1'b0, divisor};
	assign dist_sat = (quo_q > COUNT_WIDTH'(DIST_MAX)) ? '1 : quo_q[DIST_W-1:0];

	always_comb begin
		state_nx = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty && q_ctl.measure) begin
					state_nx = BK_DIV;
				end
			end
			BK_DIV: begin
				if (cnt_q == '0) begin
					state_nx = BK_DONE;
				end
			end
			BK_DONE: begin
				if (slot_free) begin
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		load_div   = 1'b0;
		div_step   = 1'b0;
		emit_plain = 1'b0;
		emit_meas  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					if (q_ctl.measure) begin
						q_pop    = 1'b1;
						load_div = 1'b1;
					end else if (slot_free) begin
						q_pop      = 1'b1;
						emit_plain = 1'b1;
					end
				end
			end
			BK_DIV:  div_step = 1'b1;
			BK_DONE: emit_meas = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			last_dist_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load_div) begin
				cnt_q <= CNT_W'(COUNT_WIDTH - 1);
			end else if (div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (emit_meas) begin
				last_dist_q <= dist_sat;
			end
			if (emit_plain || emit_meas) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_div) begin
			ctl_q <= q_ctl;
			quo_q <= q_dividend;
			rem_q <= '0;
		end else if (div_step) begin
			quo_q <= {quo_q[COUNT_WIDTH-2:0], ge};
			rem_q <= ge ? diff[TPC_W-1:0] : shifted[TPC_W-1:0];
		end
		if (emit_meas) begin
			out_trig_q  <= ctl_q.trigger;
			out_armed_q <= ctl_q.armed;
			out_dist_q  <= dist_sat;
			out_dv_q    <= 1'b1;
		end else if (emit_plain) begin
			out_trig_q  <= q_ctl.trigger;
			out_armed_q <= q_ctl.armed;
			out_dist_q  <= last_dist_q;
			out_dv_q    <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign trigger_level  = out_trig_q;
	assign distance_cm    = out_dist_q;
	assign distance_valid = out_dv_q;
	assign armed          = out_armed_q;

endmodule

// ----- hdl/ultrasonic_echo_ranger_top.sv -----
// Path: with an empty queue a plain tick is written into the queue, taken by the back end
// and its result registered; a tick that ends an echo passes the back end in steps (load,
// one quotient bit a cycle, emit), and the emit waits for a free output slot.
// Flow: one tick per cycle into the queue until QUEUE_DEPTH ticks wait; the back end drains
// one plain tick per cycle while its output is taken, and no tick during a measurement.
// Reset: registers return to their defaults, the phase to gap wait, the queue empties.
`include "assert_macros.svh"

module ultrasonic_echo_ranger_top #(
	parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF,
	parameter int QUEUE_DEPTH = uer_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            echo_level,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            trigger_level,
	output logic [uer_pkg::DIST_W-1:0]      distance_cm,
	output logic                            distance_valid,
	output logic                            armed
);
	import uer_pkg::*;

	localparam int FIFO_W = CTL_W + COUNT_WIDTH;

	logic [TPC_W-1:0]       ticks_per_cm_q;
	logic [TRIG_W-1:0]      trigger_high_q;
	logic [PRE_W-1:0]       pre_low_q;
	logic [GAP_W-1:0]       repeat_gap_q;

	logic                   q_full, q_empty, q_push, q_pop;
	tick_ctl_t              wr_ctl, rd_ctl;
	logic [COUNT_WIDTH-1:0] wr_dividend, rd_dividend;
	logic [FIFO_W-1:0]      q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_cm_q <= TPC_RST;
			trigger_high_q <= TRIG_RST;
			pre_low_q      <= PRE_RST;
			repeat_gap_q   <= GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICKS_PER_CM: ticks_per_cm_q <= cfg_data[TPC_W-1:0];
				REG_TRIGGER_HIGH: trigger_high_q <= cfg_data[TRIG_W-1:0];
				REG_PRE_LOW:      pre_low_q      <= cfg_data[PRE_W-1:0];
				REG_REPEAT_GAP:   repeat_gap_q   <= cfg_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	uer_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.echo_level        (echo_level),
		.trigger_high_ticks(trigger_high_q),
		.pre_low_ticks     (pre_low_q),
		.repeat_gap_ticks  (repeat_gap_q),
		.q_full            (q_full),
		.q_push            (q_push),
		.q_ctl             (wr_ctl),
		.q_dividend        (wr_dividend)
	);

	assign q_wdata     = {wr_ctl, wr_dividend};
	assign rd_ctl      = tick_ctl_t'(q_rdata[FIFO_W-1 -: CTL_W]);
	assign rd_dividend = q_rdata[COUNT_WIDTH-1:0];

	uer_fifo #(
		.WIDTH(FIFO_W),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	uer_back #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.ticks_per_cm  (ticks_per_cm_q),
		.q_empty       (q_empty),
		.q_ctl         (rd_ctl),
		.q_dividend    (rd_dividend),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.trigger_level (trigger_level),
		.distance_cm   (distance_cm),
		.distance_valid(distance_valid),
		.armed         (armed)
	);

	// The back end never takes an entry from an empty queue.
	`UER_ASSERT_IMPL(a_pop_nonempty, q_pop, !q_empty)
	// The queue holds at least one entry in the cycle after a tick is transferred.
	`UER_ASSERT_NEXT(a_push_lands, q_push, !q_empty)
	// The trigger is only driven while a measurement is armed.
	`UER_ASSERT_IMPL(a_trigger_armed, out_valid && trigger_level, armed)

endmodule

// ----- tb/ranger_tick_checker.sv -----
module ranger_tick_checker #(
	parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            echo_level,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic                            trigger_level,
	input  logic [uer_pkg::DIST_W-1:0]      distance_cm,
	input  logic                            distance_valid,
	input  logic                            armed,
	output int unsigned                     fail_count,
	output int unsigned                     waiting_count,
	output int unsigned                     measure_count
);
	import uer_pkg::*;

	typedef struct packed {
		logic              trigger;
		logic [DIST_W-1:0] distance;
		logic              fresh;
		logic              armed;
	} tick_result_t;

	localparam logic [31:0] ECHO_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

	logic [TPC_W-1:0]  tpc;
	logic [TRIG_W-1:0] trig_len;
	logic [PRE_W-1:0]  pre_len;
	logic [GAP_W-1:0]  gap_len;

	phase_t            ph;
	logic [31:0]       ph_ticks;
	logic [31:0]       echo_cnt;
	logic              prev_echo;
	logic [DIST_W-1:0] last_dist;

	tick_result_t      expected_ticks[$];

	function automatic logic is_timed(input phase_t p);
		return p == PH_GAP || p == PH_PRE_LOW || p == PH_HIGH;
	endfunction

	function automatic logic [31:0] timed_len(input phase_t p);
		case (p)
			PH_GAP:     return 32'(gap_len);
			PH_PRE_LOW: return 32'(pre_len);
			default:    return (trig_len == '0) ? 32'd1 : 32'(trig_len);
		endcase
	endfunction

	function automatic tick_result_t predict_tick(input logic echo);
		tick_result_t r;
		logic         rise;
		logic         fall;
		logic         fresh;
		logic [31:0]  div;
		logic [31:0]  quo;
		rise = echo && !prev_echo;
		fall = !echo && prev_echo;
		fresh = 1'b0;
		if (ph == PH_WAIT_RISE) begin
			if (rise) begin
				echo_cnt = 32'd1;
				ph = PH_COUNTING;
			end
		end else if (ph == PH_COUNTING) begin
			if (fall) begin
				div = (tpc == '0) ? 32'd1 : 32'(tpc);
				quo = echo_cnt / div;
				last_dist = (quo > DIST_MAX) ? DIST_W'(DIST_MAX) : quo[DIST_W-1:0];
				fresh = 1'b1;
				ph = PH_GAP;
				ph_ticks = 32'd0;
			end else if (echo && echo_cnt < ECHO_MAX) begin
				echo_cnt = echo_cnt + 32'd1;
			end
		end
		// Zero-length phases fall through, so up to two can pass in one tick.
		repeat (3) begin
			if (is_timed(ph) && ph_ticks >= timed_len(ph)) begin
				case (ph)
					PH_GAP:     ph = PH_PRE_LOW;
					PH_PRE_LOW: ph = PH_HIGH;
					default:    ph = PH_WAIT_RISE;
				endcase
				ph_ticks = 32'd0;
			end
		end
		if (is_timed(ph))
			ph_ticks = ph_ticks + 32'd1;
		prev_echo = echo;
		r.trigger = (ph == PH_HIGH);
		r.distance = last_dist;
		r.fresh = fresh;
		r.armed = (ph == PH_HIGH || ph == PH_WAIT_RISE || ph == PH_COUNTING);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_result_t got;
		tick_result_t want;
		if (!arst_n) begin
			tpc = TPC_RST;
			trig_len = TRIG_RST;
			pre_len = PRE_RST;
			gap_len = GAP_RST;
			ph = PH_GAP;
			ph_ticks = 32'd0;
			echo_cnt = 32'd0;
			prev_echo = 1'b0;
			last_dist = '0;
			expected_ticks.delete();
			fail_count = 0;
			waiting_count = 0;
			measure_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {trigger_level, distance_cm, distance_valid, armed};
				if (expected_ticks.size() == 0) begin
					fail_count++;
					$display("%0t: result with no tick pending: trigger %b distance %0d valid %b armed %b",
						$time, got.trigger, got.distance, got.fresh, got.armed);
				end else begin
					want = expected_ticks.pop_front();
					if (got !== want) begin
						fail_count++;
						$display("%0t: expected trigger %b distance %0d valid %b armed %b, actual trigger %b distance %0d valid %b armed %b",
							$time, want.trigger, want.distance, want.fresh, want.armed,
							got.trigger, got.distance, got.fresh, got.armed);
					end
					if (want.fresh)
						measure_count++;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_TICKS_PER_CM: tpc = cfg_data[TPC_W-1:0];
					REG_TRIGGER_HIGH: trig_len = cfg_data[TRIG_W-1:0];
					REG_PRE_LOW:      pre_len = cfg_data[PRE_W-1:0];
					REG_REPEAT_GAP:   gap_len = cfg_data[GAP_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_ticks.push_back(predict_tick(echo_level));
			waiting_count = expected_ticks.size();
		end
	end

endmodule

// ----- tb/ultrasonic_echo_ranger_top_test.sv -----
module ultrasonic_echo_ranger_top_test;
	import uer_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd9;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = COUNT_WIDTH_DEF + 8;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  echo_level = 1'b0;
	logic                  out_ready = 1'b0;
	logic                  in_ready;
	logic                  out_valid;
	logic                  trigger_level;
	logic [DIST_W-1:0]     distance_cm;
	logic                  distance_valid;
	logic                  armed;

	int unsigned fail_count;
	int unsigned waiting_count;
	int unsigned measure_count;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int ticks_sent = 0;
	int settings_used = 0;

	int cur_tpc;
	int cur_trig;
	int cur_pre;
	int cur_gap;

	always #5 clk = ~clk;

	ultrasonic_echo_ranger_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.echo_level(echo_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.trigger_level(trigger_level),
		.distance_cm(distance_cm),
		.distance_valid(distance_valid),
		.armed(armed)
	);

	ranger_tick_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.echo_level(echo_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.trigger_level(trigger_level),
		.distance_cm(distance_cm),
		.distance_valid(distance_valid),
		.armed(armed),
		.fail_count(fail_count),
		.waiting_count(waiting_count),
		.measure_count(measure_count)
	);

	// Receiver: a requested hold keeps ready low for a long stretch, otherwise random stalls.
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	task automatic send_tick(input logic e);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		echo_level <= e;
		do @(posedge clk); while (!in_ready);
		ticks_sent++;
	endtask

	task automatic send_run(input logic e, input int n);
		repeat (n) send_tick(e);
	endtask

	// Low stretch, high stretch, then the tick on which the echo falls.
	task automatic pulse(input int low_n, input int high_n);
		send_run(1'b0, low_n);
		send_run(1'b1, high_n);
		send_tick(1'b0);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (waiting_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
	endtask

	task automatic set_config(input int tpc, input int trig, input int pre, input int gap);
		cfg_put(REG_TICKS_PER_CM, tpc);
		cfg_put(REG_TRIGGER_HIGH, trig);
		cfg_put(REG_PRE_LOW, pre);
		cfg_put(REG_REPEAT_GAP, gap);
		cfg_put(REG_UNUSED, int'($urandom));
		cfg_we <= 1'b0;
		cur_tpc = tpc;
		cur_trig = trig;
		cur_pre = pre;
		cur_gap = gap;
		settings_used++;
	endtask

	// Ticks from the end of a measurement until the block waits for the next echo rise.
	function automatic int arm_span();
		return cur_gap + cur_pre + ((cur_trig == 0) ? 1 : cur_trig);
	endfunction

	task automatic random_setting();
		int tpc;
		case ($urandom_range(7))
			0:       tpc = 0;
			1:       tpc = $urandom_range(512, 1023);
			default: tpc = $urandom_range(1, 8);
		endcase
		set_config(tpc, $urandom_range(0, 4), $urandom_range(0, 3), $urandom_range(0, 4));
	endtask

	initial begin
		int start;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(1, 1, 0, 1);
		pulse(4, 1);
		pulse(4, 2);

		// Zero divisor and zero trigger length both act as one.
		settle();
		set_config(0, 0, 3, 2);
		pulse(arm_span() + 2, 5);

		// Echo edges during the trigger pulse, then echo already high when arming.
		settle();
		set_config(1, 6, 4, 1);
		send_run(1'b0, 6);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_run(1'b1, 10);
		pulse(3, 4);

		settle();
		set_config(13, 8, 2, 3);
		pulse(arm_span() + 2, 40);
		pulse(arm_span() + 2, 12);

		// The longest gap, cut short by a later write; an echo in the gap is ignored.
		settle();
		set_config(58, 10, 5, 24'hFFFFFF);
		send_run(1'b0, 40);
		pulse(0, 2);
		settle();
		set_config(6, 10, 5, 0);
		pulse(arm_span() + 3, 30);
		pulse(arm_span() + 1, 12);

		for (int phase_no = 0; phase_no < 4; phase_no++) begin
			case (phase_no)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 77; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 77; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			repeat (2) begin
				settle();
				random_setting();
				// With the receiver held off, the sender keeps offering until the queue fills.
				if (phase_no == 0 && hold_req == 0)
					hold_req = 1;
				start = ticks_sent;
				while (ticks_sent - start < 55) begin
					if ($urandom_range(99) < 80)
						pulse(arm_span() + $urandom_range(0, 2), $urandom_range(1, 12));
					else
						pulse($urandom_range(0, arm_span()), $urandom_range(1, 3));
				end
			end
		end

		settle();
		$display("Covered %0d ticks under %0d register settings and four idle patterns.",
			ticks_sent, settings_used);
		$display("%0d distance measurements were checked.", measure_count);
		if (fail_count == 0 && waiting_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
